/* hdl/priority_shape_region_fill_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the shape region fill block
// Concurrent checks on a clock with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_SHAPE_REGION_FILL_MACROS_SVH
`define PRIORITY_SHAPE_REGION_FILL_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define PSRF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psrf check failed");

// Next-cycle implication
`define PSRF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psrf check failed");

`else

`define PSRF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSRF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/psrf_pkg.sv */
// ----------------------------------------------------------------------------
// psrf_pkg
// Types and constants shared by the shape region fill block.
// ----------------------------------------------------------------------------
package psrf_pkg;

  localparam int MAX_STATES_DEF = 16;
  localparam int CNT_W          = 5;
  localparam int COORD_W        = 32;
  localparam int VAL_W          = 32;
  localparam int PROD_W         = 64;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef enum logic [1:0] {
    SHAPE_RECT   = 2'd0,
    SHAPE_CIRCLE = 2'd1,
    SHAPE_POINT  = 2'd2,
    SHAPE_NONE   = 2'd3
  } shape_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_MUL,
    ST_PUSH
  } fsm_t;

  // One material state as stored in the table memory
  typedef struct packed {
    shape_t                    shape;
    logic [VAL_W-1:0]          density;
    logic [VAL_W-1:0]          energy;
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] low;
    logic signed [COORD_W-1:0] high;
  } entry_t;

  // Geometry of the cell under evaluation
  typedef struct packed {
    logic signed [COORD_W-1:0] lx;
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ly;
    logic signed [COORD_W-1:0] hy;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic                      interior;
  } cell_t;

endpackage

/* hdl/psrf_in_if.sv */
// ----------------------------------------------------------------------------
// psrf_in_if
// Request channel: load a table entry or evaluate one cell.
// ----------------------------------------------------------------------------
interface psrf_in_if;
  import psrf_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [CNT_W-1:0]          entry_index;
  logic [1:0]                shape_kind;
  logic [VAL_W-1:0]          entry_density;
  logic [VAL_W-1:0]          entry_energy;
  logic signed [COORD_W-1:0] left_x;
  logic signed [COORD_W-1:0] right_x;
  logic signed [COORD_W-1:0] low_y;
  logic signed [COORD_W-1:0] high_y;
  logic signed [COORD_W-1:0] centre_x;
  logic signed [COORD_W-1:0] centre_y;
  logic                      interior;

  modport source (
    output valid, action, entry_index, shape_kind, entry_density, entry_energy,
           left_x, right_x, low_y, high_y, centre_x, centre_y, interior,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, shape_kind, entry_density, entry_energy,
           left_x, right_x, low_y, high_y, centre_x, centre_y, interior,
    output ready
  );

endinterface

/* hdl/psrf_out_if.sv */
// ----------------------------------------------------------------------------
// psrf_out_if
// Result channel: values of the winning material state.
// ----------------------------------------------------------------------------
interface psrf_out_if;
  import psrf_pkg::*;

  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  out_density;
  logic [VAL_W-1:0]  out_energy;
  logic [PROD_W-1:0] out_product;
  logic [CNT_W-1:0]  winning_entry;

  modport source (
    output valid, out_density, out_energy, out_product, winning_entry,
    input  ready
  );

  modport sink (
    input  valid, out_density, out_energy, out_product, winning_entry,
    output ready
  );

endinterface

/* hdl/psrf_ram.sv */
// ----------------------------------------------------------------------------
// psrf_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module psrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/priority_shape_region_fill.sv */
// Load request: accepted while idle, writes one table entry if its index is in 1..MAX_STATES, no result.
// Evaluate request: n = max(1, min(state_count, MAX_STATES)) entries are read
// from the table memory, one per cycle; a result is offered after the walk,
// the pipeline drain, the multiply and the push, and no new request is taken
// until the result is in the output register, which a waiting result holds.
// Synchronous active-low reset clears control state and sets state_count to 1.
// ----------------------------------------------------------------------------
// priority_shape_region_fill
// Walks the material table for one cell; the last matching entry wins.
// ----------------------------------------------------------------------------
`include "priority_shape_region_fill_macros.svh"

module priority_shape_region_fill #(
  parameter int MAX_STATES = psrf_pkg::MAX_STATES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [psrf_pkg::CNT_W-1:0] cfg_wdata,
  psrf_in_if.sink                    in_ch,
  psrf_out_if.source                 out_ch
);
  import psrf_pkg::*;

  localparam int IW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int EW = $bits(entry_t);

  fsm_t             state_r, state_nxt;
  logic [CNT_W-1:0] state_count_r;

  logic             in_acc, in_ready, rd_en, out_load;
  logic             load_ok;

  cell_t            cell_r;
  logic [IW-1:0]    last_r, last_nxt;
  logic [IW-1:0]    rd_cnt_r;

  logic [IW-1:0]    waddr;
  entry_t           wentry;
  logic [EW-1:0]    rdata;
  entry_t           ent;

  // stage 1: memory data returns
  logic             s1_vld_r;
  logic [IW-1:0]    s1_idx_r;

  // stage 2: compares and distances
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        ax, ay;
  logic                    rect_hit, pt_hit, simple_hit, circ_ok;
  logic                    s2_vld_r, s2_simple_r, s2_circ_r;
  logic [IW-1:0]           s2_idx_r;
  logic [COORD_W-1:0]      s2_ax_r, s2_ay_r;
  logic [COORD_W-2:0]      s2_rad_r;
  logic [VAL_W-1:0]        s2_den_r, s2_eng_r;

  // stage 3: squares
  logic                    s3_vld_r, s3_simple_r, s3_circ_r;
  logic [IW-1:0]           s3_idx_r;
  logic [2*COORD_W-1:0]    s3_sx_r, s3_sy_r;
  logic [2*COORD_W-3:0]    s3_rr_r;
  logic [VAL_W-1:0]        s3_den_r, s3_eng_r;
  logic [2*COORD_W:0]      dist_sum;
  logic                    hit;

  logic [CNT_W-1:0]  win_r;
  logic [VAL_W-1:0]  win_den_r, win_eng_r;
  logic [PROD_W-1:0] prod_r;

  logic              out_vld_r;
  logic [VAL_W-1:0]  out_den_r, out_eng_r;
  logic [PROD_W-1:0] out_prod_r;
  logic [CNT_W-1:0]  out_win_r;

  assign in_acc      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid && in_ch.action == ACT_EVAL) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en = 1'b1;
        if (rd_cnt_r == last_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r && !s3_vld_r) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        // hold until the output register is free
        if (!out_vld_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      state_count_r <= cfg_wdata;
    end
  end

  // clamp the walk length to 1..MAX_STATES entries
  always_comb begin
    if (state_count_r == '0) begin
      last_nxt = '0;
    end else if (32'(state_count_r) > 32'(MAX_STATES)) begin
      last_nxt = IW'(MAX_STATES - 1);
    end else begin
      last_nxt = IW'(state_count_r - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.action == ACT_EVAL) begin
      cell_r.lx       <= in_ch.left_x;
      cell_r.rx       <= in_ch.right_x;
      cell_r.ly       <= in_ch.low_y;
      cell_r.hy       <= in_ch.high_y;
      cell_r.cx       <= in_ch.centre_x;
      cell_r.cy       <= in_ch.centre_y;
      cell_r.interior <= in_ch.interior;
      last_r          <= last_nxt;
      rd_cnt_r        <= '0;
    end else if (rd_en) begin
      rd_cnt_r <= rd_cnt_r + IW'(1);
    end
  end

  // ---------------------------------------------------------------- table
  assign load_ok = in_acc && in_ch.action == ACT_LOAD && in_ch.entry_index != '0 &&
                   32'(in_ch.entry_index) <= 32'(MAX_STATES);
  assign waddr   = IW'(in_ch.entry_index - CNT_W'(1));

  always_comb begin
    wentry.shape   = shape_t'(in_ch.shape_kind);
    wentry.density = in_ch.entry_density;
    wentry.energy  = in_ch.entry_energy;
    wentry.left    = in_ch.left_x;
    wentry.right   = in_ch.right_x;
    wentry.low     = in_ch.low_y;
    wentry.high    = in_ch.high_y;
  end

  psrf_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_STATES),
    .AW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (load_ok),
    .waddr (waddr),
    .wdata (wentry),
    .re    (rd_en),
    .raddr (rd_cnt_r),
    .rdata (rdata)
  );

  assign ent = entry_t'(rdata);

  // ---------------------------------------------------------------- match pipe
  always_comb begin
    dx = {cell_r.cx[COORD_W-1], cell_r.cx} - {ent.left[COORD_W-1], ent.left};
    dy = {cell_r.cy[COORD_W-1], cell_r.cy} - {ent.low[COORD_W-1], ent.low};
    ax = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
    ay = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);

    rect_hit = cell_r.interior && (cell_r.rx >= ent.left) && (cell_r.lx < ent.right) &&
               (cell_r.hy >= ent.low) && (cell_r.ly < ent.high);
    pt_hit   = (cell_r.lx == ent.left) && (cell_r.ly == ent.low);
    circ_ok  = (ent.shape == SHAPE_CIRCLE) && !ent.right[COORD_W-1];

    case (ent.shape)
      SHAPE_RECT:  simple_hit = rect_hit;
      SHAPE_POINT: simple_hit = pt_hit;
      default:     simple_hit = 1'b0;
    endcase
    // the first entry is the background and always applies
    if (s1_idx_r == '0) begin
      simple_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= rd_en;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r    <= rd_cnt_r;

    s2_idx_r    <= s1_idx_r;
    s2_simple_r <= simple_hit;
    s2_circ_r   <= circ_ok && (s1_idx_r != '0);
    s2_ax_r     <= ax[COORD_W-1:0];
    s2_ay_r     <= ay[COORD_W-1:0];
    s2_rad_r    <= ent.right[COORD_W-2:0];
    s2_den_r    <= ent.density;
    s2_eng_r    <= ent.energy;

    s3_idx_r    <= s2_idx_r;
    s3_simple_r <= s2_simple_r;
    s3_circ_r   <= s2_circ_r;
    s3_sx_r     <= (2*COORD_W)'(s2_ax_r) * (2*COORD_W)'(s2_ax_r);
    s3_sy_r     <= (2*COORD_W)'(s2_ay_r) * (2*COORD_W)'(s2_ay_r);
    s3_rr_r     <= (2*COORD_W-2)'(s2_rad_r) * (2*COORD_W-2)'(s2_rad_r);
    s3_den_r    <= s2_den_r;
    s3_eng_r    <= s2_eng_r;
  end

  assign dist_sum = {1'b0, s3_sx_r} + {1'b0, s3_sy_r};
  assign hit      = s3_vld_r &&
                    (s3_simple_r || (s3_circ_r && dist_sum <= {3'b000, s3_rr_r}));

  // entries arrive in order, so a later hit simply overwrites
  always_ff @(posedge clk) begin
    if (hit) begin
      win_r     <= CNT_W'(s3_idx_r) + CNT_W'(1);
      win_den_r <= s3_den_r;
      win_eng_r <= s3_eng_r;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(win_den_r) * PROD_W'(win_eng_r);
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_den_r  <= win_den_r;
      out_eng_r  <= win_eng_r;
      out_prod_r <= prod_r;
      out_win_r  <= win_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.out_density   = out_den_r;
  assign out_ch.out_energy    = out_eng_r;
  assign out_ch.out_product   = out_prod_r;
  assign out_ch.winning_entry = out_win_r;

  // ---------------------------------------------------------------- checks
  `PSRF_ASSERT_IMP(a_pipe_in_walk, clk, rst_n, s1_vld_r || s2_vld_r || s3_vld_r,
                   state_r == ST_WALK || state_r == ST_DRAIN)
  `PSRF_ASSERT_IMP(a_read_in_range, clk, rst_n, rd_en, rd_cnt_r <= last_r)
  `PSRF_ASSERT_IMP(a_win_in_range, clk, rst_n, state_r == ST_MUL,
                   win_r != '0 && 32'(win_r) <= 32'(last_r) + 32'd1)
  `PSRF_ASSERT_NXT(a_push_done, clk, rst_n, out_load, out_vld_r && state_r == ST_IDLE)

endmodule

/* tb/psrf_fill_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrf_fill_checker
// Watches the request and fill channels of the shape region fill block.
// Keeps its own material table and state count, predicts the fill of each
// evaluated cell and compares every returned fill field by field.
// ----------------------------------------------------------------------------
module psrf_fill_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [psrf_pkg::CNT_W-1:0] cfg_wdata,
  psrf_in_if                         req_mon,
  psrf_out_if                        fill_mon,
  output int                         fills_outstanding,
  output int                         mismatch_count
);
  import psrf_pkg::*;

  typedef struct {
    logic [VAL_W-1:0]  density;
    logic [VAL_W-1:0]  energy;
    logic [PROD_W-1:0] product;
    logic [CNT_W-1:0]  winner;
  } fill_t;

  entry_t           materials [MAX_STATES_DEF];
  logic [CNT_W-1:0] count_reg;
  fill_t            expected_fills [$];
  int               errors;

  initial begin
    fills_outstanding = 0;
    mismatch_count    = 0;
    errors            = 0;
    count_reg         = 1;
  end

  function automatic bit material_covers(entry_t m, cell_t probe);
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W-1:0]      ax, ay;
    logic [63:0]             sqx, sqy, rad2;
    logic [64:0]             dist2;
    case (m.shape)
      SHAPE_RECT: begin
        return probe.interior &&
               ($signed(probe.rx) >= $signed(m.left)) &&
               ($signed(probe.lx) <  $signed(m.right)) &&
               ($signed(probe.hy) >= $signed(m.low)) &&
               ($signed(probe.ly) <  $signed(m.high));
      end
      SHAPE_CIRCLE: begin
        // negative radius never matches
        if (m.right[COORD_W-1]) return 1'b0;
        dx    = {probe.cx[COORD_W-1], probe.cx} - {m.left[COORD_W-1], m.left};
        dy    = {probe.cy[COORD_W-1], probe.cy} - {m.low[COORD_W-1], m.low};
        ax    = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
        ay    = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
        sqx   = 64'(ax) * 64'(ax);
        sqy   = 64'(ay) * 64'(ay);
        // keep the carry: a sum past 64 bits is beyond any radius
        dist2 = 65'(sqx) + 65'(sqy);
        rad2  = 64'(m.right[COORD_W-2:0]) * 64'(m.right[COORD_W-2:0]);
        return dist2 <= 65'(rad2);
      end
      SHAPE_POINT: return (probe.lx == m.left) && (probe.ly == m.low);
      default:     return 1'b0;
    endcase
  endfunction

  function automatic fill_t fill_cell(cell_t probe);
    int    span;
    int    winner;
    fill_t f;
    if (count_reg > MAX_STATES_DEF) span = MAX_STATES_DEF;
    else if (count_reg == 0)        span = 1;
    else                            span = count_reg;
    winner = 1;
    for (int s = 2; s <= span; s++) begin
      if (material_covers(materials[s-1], probe)) winner = s;
    end
    f.density = materials[winner-1].density;
    f.energy  = materials[winner-1].energy;
    f.product = 64'(f.density) * 64'(f.energy);
    f.winner  = CNT_W'(winner);
    return f;
  endfunction

  function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    fill_t want;
    cell_t probe;
    bit    ok;
    if (!rst_n) begin
      count_reg = 1;
      expected_fills.delete();
      foreach (materials[i]) materials[i] = '0;
    end else begin
      if (cfg_we) count_reg = cfg_wdata;

      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.action == ACT_LOAD) begin
          // drop loads outside the table
          if (req_mon.entry_index >= 1 && req_mon.entry_index <= MAX_STATES_DEF) begin
            materials[req_mon.entry_index - 1] = '{
              shape:   shape_t'(req_mon.shape_kind),
              density: req_mon.entry_density,
              energy:  req_mon.entry_energy,
              left:    req_mon.left_x,
              right:   req_mon.right_x,
              low:     req_mon.low_y,
              high:    req_mon.high_y
            };
          end
        end else begin
          probe = '{
            lx: req_mon.left_x, rx: req_mon.right_x,
            ly: req_mon.low_y,  hy: req_mon.high_y,
            cx: req_mon.centre_x, cy: req_mon.centre_y,
            interior: req_mon.interior
          };
          expected_fills.push_back(fill_cell(probe));
        end
      end

      if (fill_mon.valid && fill_mon.ready) begin
        if (expected_fills.size() == 0) begin
          $error("fill returned with no request waiting: winning_entry %0d",
                 fill_mon.winning_entry);
          errors++;
        end else begin
          want = expected_fills.pop_front();
          ok = field_ok("out_density", 64'(want.density), 64'(fill_mon.out_density));
          ok = field_ok("out_energy", 64'(want.energy), 64'(fill_mon.out_energy)) && ok;
          ok = field_ok("out_product", want.product, fill_mon.out_product) && ok;
          ok = field_ok("winning_entry", 64'(want.winner), 64'(fill_mon.winning_entry))
               && ok;
          if (!ok) errors++;
        end
      end
    end
    fills_outstanding <= expected_fills.size();
    mismatch_count    <= errors;
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives load and evaluate requests and state count writes into the shape
// region fill block with random gaps and fill-side stalls; the checker beside
// the block predicts and compares every fill.
// ----------------------------------------------------------------------------
module tb_top;
  import psrf_pkg::*;

  typedef struct {
    logic                      action;
    logic [CNT_W-1:0]          entry_index;
    logic [1:0]                shape_kind;
    logic [VAL_W-1:0]          entry_density;
    logic [VAL_W-1:0]          entry_energy;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] low_y;
    logic signed [COORD_W-1:0] high_y;
    logic signed [COORD_W-1:0] centre_x;
    logic signed [COORD_W-1:0] centre_y;
    logic                      interior;
  } request_t;

  localparam int PHASES         = 8;
  localparam int PHASE_REQUESTS = 100;
  localparam int SETTLE_CYCLES  = 30;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  int               fills_outstanding;
  int               mismatch_count;
  bit               quiet;
  int               stall_left;

  logic signed [COORD_W-1:0] spot_x [$];
  logic signed [COORD_W-1:0] spot_y [$];

  psrf_in_if  req_ch ();
  psrf_out_if fill_ch ();

  priority_shape_region_fill dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_ch),
    .out_ch    (fill_ch)
  );

  psrf_fill_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .req_mon           (req_ch),
    .fill_mon          (fill_ch),
    .fills_outstanding (fills_outstanding),
    .mismatch_count    (mismatch_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Fill side: mostly ready, short stalls and now and then a long one
  initial begin
    fill_ch.ready = 1'b0;
    stall_left    = 0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      fill_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                : $urandom_range(8, 40);
      fill_ch.ready <= 1'b0;
    end else begin
      fill_ch.ready <= 1'b1;
    end
  end

  function automatic int idle_span();
    int unsigned p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    int unsigned p;
    p = $urandom_range(0, 99);
    // a coarse grid in [-4.0, 4.0] so shapes and cells overlap often
    if (p < 65) return COORD_W'($urandom_range(0, 16) * 32'h8000 - 32'h40000);
    if (p < 85) return COORD_W'($urandom_range(0, 32'h80000) - 32'h40000);
    if (p < 95) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 88) return $urandom;
    if (p < 94) return '0;
    return '1;
  endfunction

  function automatic request_t load_req(logic [CNT_W-1:0] idx, shape_t shape,
                                        logic [VAL_W-1:0] dens, logic [VAL_W-1:0] enrg,
                                        logic signed [COORD_W-1:0] lft,
                                        logic signed [COORD_W-1:0] rgt,
                                        logic signed [COORD_W-1:0] lo,
                                        logic signed [COORD_W-1:0] hi);
    request_t r;
    r.action        = ACT_LOAD;
    r.entry_index   = idx;
    r.shape_kind    = shape;
    r.entry_density = dens;
    r.entry_energy  = enrg;
    r.left_x        = lft;
    r.right_x       = rgt;
    r.low_y         = lo;
    r.high_y        = hi;
    r.centre_x      = $urandom;
    r.centre_y      = $urandom;
    r.interior      = $urandom_range(0, 1);
    return r;
  endfunction

  function automatic request_t cell_req(logic signed [COORD_W-1:0] lx,
                                        logic signed [COORD_W-1:0] rx,
                                        logic signed [COORD_W-1:0] ly,
                                        logic signed [COORD_W-1:0] hy,
                                        logic signed [COORD_W-1:0] cx,
                                        logic signed [COORD_W-1:0] cy,
                                        logic inside_domain);
    request_t r;
    r.action        = ACT_EVAL;
    r.entry_index   = CNT_W'($urandom);
    r.shape_kind    = 2'($urandom);
    r.entry_density = $urandom;
    r.entry_energy  = $urandom;
    r.left_x        = lx;
    r.right_x       = rx;
    r.low_y         = ly;
    r.high_y        = hy;
    r.centre_x      = cx;
    r.centre_y      = cy;
    r.interior      = inside_domain;
    return r;
  endfunction

  function automatic request_t random_load();
    logic [CNT_W-1:0]          idx;
    shape_t                    shape;
    logic signed [COORD_W-1:0] lft, rgt, lo, hi, t;
    idx   = ($urandom_range(0, 99) < 93) ? CNT_W'($urandom_range(1, MAX_STATES_DEF))
                                         : CNT_W'($urandom_range(0, 1) ? 0
                                                  : $urandom_range(17, 31));
    shape = shape_t'($urandom_range(0, 3));
    lft   = pick_coord();
    rgt   = pick_coord();
    lo    = pick_coord();
    hi    = pick_coord();
    // mostly well-ordered bounds
    if ($urandom_range(0, 99) < 80) begin
      if (lft > rgt) begin t = lft; lft = rgt; rgt = t; end
      if (lo > hi)   begin t = lo;  lo  = hi;  hi  = t; end
    end
    if (shape == SHAPE_CIRCLE && $urandom_range(0, 99) < 85)
      rgt = COORD_W'($urandom_range(0, 8) * 32'h8000);
    if (shape == SHAPE_POINT && idx >= 1 && idx <= MAX_STATES_DEF) begin
      spot_x.push_back(lft);
      spot_y.push_back(lo);
    end
    return load_req(idx, shape, pick_value(), pick_value(), lft, rgt, lo, hi);
  endfunction

  function automatic request_t random_cell();
    logic signed [COORD_W-1:0] lx, rx, ly, hy, cx, cy;
    int                        k;
    lx = pick_coord();
    ly = pick_coord();
    if (spot_x.size() > 0 && $urandom_range(0, 99) < 25) begin
      k  = $urandom_range(0, spot_x.size() - 1);
      lx = spot_x[k];
      ly = spot_y[k];
    end
    rx = ($urandom_range(0, 99) < 85) ? lx + COORD_W'($urandom_range(0, 32'h20000))
                                      : pick_coord();
    hy = ($urandom_range(0, 99) < 85) ? ly + COORD_W'($urandom_range(0, 32'h20000))
                                      : pick_coord();
    cx = ($urandom_range(0, 99) < 70) ? (lx >>> 1) + (rx >>> 1) : pick_coord();
    cy = ($urandom_range(0, 99) < 70) ? (ly >>> 1) + (hy >>> 1) : pick_coord();
    return cell_req(lx, rx, ly, hy, cx, cy, $urandom_range(0, 99) < 85);
  endfunction

  // Call at a rising edge; returns at the edge that accepts the request
  task automatic send_request(input request_t r);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= r.action;
    req_ch.entry_index   <= r.entry_index;
    req_ch.shape_kind    <= r.shape_kind;
    req_ch.entry_density <= r.entry_density;
    req_ch.entry_energy  <= r.entry_energy;
    req_ch.left_x        <= r.left_x;
    req_ch.right_x       <= r.right_x;
    req_ch.low_y         <= r.low_y;
    req_ch.high_y        <= r.high_y;
    req_ch.centre_x      <= r.centre_x;
    req_ch.centre_y      <= r.centre_y;
    req_ch.interior      <= r.interior;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Drop valid, wait for every fill, then let a trailing walk finish
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (fills_outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    request_t         r;
    int               sent;
    logic [CNT_W-1:0] count;

    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    quiet                = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.action        = ACT_LOAD;
    req_ch.entry_index   = '0;
    req_ch.shape_kind    = '0;
    req_ch.entry_density = '0;
    req_ch.entry_energy  = '0;
    req_ch.left_x        = '0;
    req_ch.right_x       = '0;
    req_ch.low_y         = '0;
    req_ch.high_y        = '0;
    req_ch.centre_x      = '0;
    req_ch.centre_y      = '0;
    req_ch.interior      = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Background only at the reset count, then loads to indexes off the table
    send_request(load_req(1, SHAPE_RECT, 32'h0001_0000, 32'hFFFF_FFFF,
                          -32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000));
    send_request(cell_req(0, 32'sh4000, 0, 32'sh4000, 32'sh2000, 32'sh2000, 1'b1));
    send_request(load_req(0, SHAPE_POINT, '1, '1, 0, 0, 0, 0));
    send_request(load_req(31, SHAPE_POINT, '1, '1, 0, 0, 0, 0));

    send_request(load_req(2, SHAPE_RECT, '1, '1,
                          -32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000));
    send_request(load_req(3, SHAPE_CIRCLE, '0, 32'h0002_8000, 0, 32'sh8000, 0, 0));
    send_request(load_req(4, SHAPE_POINT, 32'h1234_5678, '0,
                          32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0));
    spot_x.push_back(32'sh8000_0000);
    spot_y.push_back(32'sh7FFF_FFFF);
    send_request(load_req(5, SHAPE_NONE, '1, '0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh7FFF_FFFF));
    send_request(load_req(6, SHAPE_CIRCLE, 32'h0000_0006, 32'h0000_0006,
                          0, -32'sh1, 0, 0));
    send_request(load_req(7, SHAPE_CIRCLE, 32'h0000_0007, 32'h0000_0007,
                          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
    for (int i = 8; i <= MAX_STATES_DEF; i++)
      send_request(load_req(CNT_W'(i), SHAPE_RECT, pick_value(), pick_value(),
                            32'sh0064_0000, 32'sh0065_0000, 32'sh0064_0000,
                            32'sh0065_0000));
    drain();
    write_count(CNT_W'(MAX_STATES_DEF));

    // centre inside the circle, rectangle covered too
    send_request(cell_req(-32'sh4000, 32'sh4000, -32'sh4000, 32'sh4000, 0, 0, 1'b1));
    // centre outside the circle: rectangle with and without interior
    send_request(cell_req(-32'sh4000, 32'sh4000, -32'sh4000, 32'sh4000,
                          32'sh10000, 0, 1'b1));
    send_request(cell_req(-32'sh4000, 32'sh4000, -32'sh4000, 32'sh4000,
                          32'sh10000, 0, 1'b0));
    // distance equal to the radius
    send_request(cell_req(0, 0, 0, 0, 32'sh8000, 0, 1'b0));
    // exact vertex on the point at the coordinate extremes
    send_request(cell_req(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1));
    // squared distance past 64 bits
    send_request(cell_req(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1));
    drain();
    write_count(0);
    send_request(cell_req(-32'sh4000, 32'sh4000, -32'sh4000, 32'sh4000, 0, 0, 1'b1));
    drain();
    write_count(31);
    send_request(cell_req(32'sh0064_0000, 32'sh0064_8000, 32'sh0064_0000,
                          32'sh0064_8000, 0, 0, 1'b1));

    // Random phases, each at its own state count
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       count = CNT_W'(MAX_STATES_DEF);
        1:       count = 31;
        2:       count = 0;
        3:       count = 1;
        default: count = ($urandom_range(0, 99) < 60)
                         ? CNT_W'($urandom_range(2, MAX_STATES_DEF))
                         : CNT_W'($urandom_range(0, 31));
      endcase
      write_count(count);
      quiet = (p == 2) || ($urandom_range(0, 3) == 0);
      sent  = 0;
      while (sent < PHASE_REQUESTS) begin
        r = ($urandom_range(0, 99) < 25) ? random_load() : random_cell();
        send_request(r);
        if (r.action == ACT_EVAL ||
            (r.entry_index >= 1 && r.entry_index <= MAX_STATES_DEF))
          sent++;
      end
    end

    quiet = 1'b0;
    drain();
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
